// ----- design/ole_pkg.sv -----
// Package with the constants, codes and transfer types of the ordered list engine.
package ole_pkg;

	localparam int DEPTH       = 16;
	localparam int TOKEN_WIDTH = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_GET     = 2'd1,
		CMD_DEL_IDX = 2'd2,
		CMD_DEL_VAL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef logic [TOKEN_WIDTH-1:0] tok_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  position;
		logic [31:0] token;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] read_token;
		logic [4:0]  length;
		status_t     status;
	} rsp_item_t;

	typedef struct packed {
		logic valid;
		logic idx_sel;
		logic append_sel;
		logic by_index;
		logic by_value;
		logic apply;
	} cell_ctrl_t;

endpackage

// ----- design/ole_cell.sv -----
// One storage cell of the list: holds an entry, compares it and takes its neighbor's entry.
module ole_cell (
	input  logic                clk,
	input  ole_pkg::cell_ctrl_t ctrl,
	input  ole_pkg::tok_t       token,
	input  ole_pkg::tok_t       right_entry,
	input  logic                hit_in,
	output ole_pkg::tok_t       entry,
	output logic                hit_out
);
	import ole_pkg::*;

	tok_t entry_q;
	logic match;
	logic shift;

	assign match   = ctrl.valid && (entry_q == token);
	assign hit_out = hit_in | match;
	assign shift   = (ctrl.by_index & ctrl.idx_sel) | (ctrl.by_value & hit_out);
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			if (ctrl.append_sel) begin
				entry_q <= token;
			end else if (shift) begin
				entry_q <= right_entry;
			end
		end
	end

endmodule

// ----- design/ole_chain.sv -----
// Row of list cells with per-cell control decode, first-match chain and read select.
module ole_chain (
	input  logic               clk,
	input  ole_pkg::cmd_t      cmd,
	input  logic [3:0]         position,
	input  ole_pkg::tok_t      token,
	input  ole_pkg::cnt_t      count,
	input  logic               apply,
	output logic               found,
	output ole_pkg::tok_t      read_entry
);
	import ole_pkg::*;

	tok_t entries [DEPTH];
	logic hit [DEPTH+1];

	assign hit[0] = 1'b0;
	assign found  = hit[DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cell_ctrl_t ctrl;
		tok_t       right;

		assign ctrl.valid      = 32'(g) < 32'(count);
		assign ctrl.idx_sel    = 32'(g) >= 32'(position);
		assign ctrl.append_sel = (cmd == CMD_APPEND) && (32'(g) == 32'(count));
		assign ctrl.by_index   = (cmd == CMD_DEL_IDX);
		assign ctrl.by_value   = (cmd == CMD_DEL_VAL);
		assign ctrl.apply      = apply;

		if (g == DEPTH - 1) begin : g_last
			assign right = entries[g];
		end else begin : g_mid
			assign right = entries[g+1];
		end

		ole_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.token       (token),
			.right_entry (right),
			.hit_in      (hit[g]),
			.entry       (entries[g]),
			.hit_out     (hit[g+1])
		);
	end

	always_comb begin
		read_entry = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (32'(k) == 32'(position)) begin
				read_entry = entries[k];
			end
		end
	end

endmodule

// ----- design/ordered_list_engine.sv -----
// Latency: a command transfer shows its response in the next cycle.
// Throughput: one command per cycle unless a stalled response holds cmd_stall high;
// the cell row applies append, shift and compare at once. The response register lets
// a new command in while it is being taken. Reset clears the entry count and the
// response valid; cell contents are unknown until written.
module ordered_list_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  ole_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ole_pkg::rsp_item_t rsp
);
	import ole_pkg::*;

	cnt_t      count_q;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	logic      accept;
	logic      full;
	logic      in_range;
	logic      found;
	logic      apply;
	tok_t      tok;
	tok_t      read_entry;
	cnt_t      count_nxt;
	rsp_item_t rsp_nxt;

	assign cmd_stall = rsp_valid_q & rsp_stall;
	assign accept    = cmd_valid & ~cmd_stall;
	assign tok       = TOKEN_WIDTH'(cmd.token);
	assign full      = 32'(count_q) >= 32'(DEPTH);
	assign in_range  = 32'(cmd.position) < 32'(count_q);

	always_comb begin
		count_nxt          = count_q;
		apply              = 1'b0;
		rsp_nxt.read_token = '0;
		rsp_nxt.status     = ST_OK;
		unique case (cmd.cmd)
			CMD_APPEND: begin
				if (full) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					apply     = accept;
					count_nxt = count_q + cnt_t'(1);
				end
			end
			CMD_GET: begin
				if (!in_range) begin
					rsp_nxt.status = ST_RANGE;
				end else begin
					rsp_nxt.read_token = 32'(read_entry);
				end
			end
			CMD_DEL_IDX: begin
				if (!in_range) begin
					rsp_nxt.status = ST_RANGE;
				end else begin
					apply     = accept;
					count_nxt = count_q - cnt_t'(1);
				end
			end
			CMD_DEL_VAL: begin
				if (!found) begin
					rsp_nxt.status = ST_MISSING;
				end else begin
					apply     = accept;
					count_nxt = count_q - cnt_t'(1);
				end
			end
			default: begin
				rsp_nxt.status = ST_OK;
			end
		endcase
		rsp_nxt.length = 5'(count_nxt);
	end

	ole_chain u_chain (
		.clk        (clk),
		.cmd        (cmd.cmd),
		.position   (cmd.position),
		.token      (tok),
		.count      (count_q),
		.apply      (apply),
		.found      (found),
		.read_entry (read_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- design/ole_checker.sv -----
// Port checker for the ordered list engine and its bind to the top level.
module ole_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  ole_pkg::rsp_item_t rsp
);
	import ole_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or dropped.");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> rsp_valid)
		else $error("Command transfer without a response in the next cycle.");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.length) <= 32'(DEPTH))
		else $error("Reported length exceeds capacity.");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> 32'(rsp.length) == 32'(DEPTH))
		else $error("List full reported with a short list.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_token == '0)
		else $error("Failed command returned a nonzero token.");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the ordered list engine with an in-bench list predictor.
module testbench;
	import ole_pkg::*;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	ordered_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	cmd_item_t cmd_backlog[$];
	rsp_item_t due_responses[$];
	tok_t      list_entries[DEPTH];
	int        model_len = 0;
	tok_t      token_pool[6];
	int        error_count = 0;
	int        cmds_taken = 0;
	int        rsps_taken = 0;
	int        status_seen[4] = '{0, 0, 0, 0};
	int        longest_list = 0;
	int        cyc = 0;
	logic      cmd_took = 1'b0;
	logic      hold_rsp = 1'b0;
	logic      calm;

	assign calm = (cyc >= 1500) && (cyc < 1900);

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		error_count++;
		$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	function automatic void remove_entry(input int at);
		for (int k = at; k + 1 < model_len; k++)
			list_entries[k] = list_entries[k + 1];
		model_len--;
	endfunction

	function automatic rsp_item_t list_apply(input cmd_item_t c);
		rsp_item_t r;
		int        hit;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		case (c.cmd)
			CMD_APPEND: begin
				if (model_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_entries[model_len] = c.token;
					model_len++;
				end
			end
			CMD_GET: begin
				if (int'(c.position) >= model_len)
					r.status = ST_RANGE;
				else
					r.read_token = list_entries[c.position];
			end
			CMD_DEL_IDX: begin
				if (int'(c.position) >= model_len)
					r.status = ST_RANGE;
				else
					remove_entry(int'(c.position));
			end
			default: begin
				for (int k = 0; k < model_len; k++)
					if (hit < 0 && list_entries[k] == c.token)
						hit = k;
				if (hit < 0)
					r.status = ST_MISSING;
				else
					remove_entry(hit);
			end
		endcase
		r.length = model_len[4:0];
		return r;
	endfunction

	task automatic push_cmd(input cmd_t op, input int pos, input tok_t t);
		cmd_item_t c;
		c.cmd = op;
		c.position = pos[3:0];
		c.token = t;
		cmd_backlog.push_back(c);
	endtask

	function automatic tok_t pick_token();
		if ($urandom_range(99) < 65)
			return token_pool[$urandom_range(5)];
		return $urandom;
	endfunction

	always @(posedge clk) begin : watch
		rsp_item_t want;
		if (arst_n) begin
			cyc <= cyc + 1;
			cmd_took <= cmd_valid && !cmd_stall;
			if (cmd_valid && !cmd_stall) begin
				want = list_apply(cmd);
				due_responses.push_back(want);
				cmds_taken++;
				status_seen[want.status]++;
				if (model_len > longest_list)
					longest_list = model_len;
			end
			if (rsp_valid && !rsp_stall) begin
				rsps_taken++;
				if (due_responses.size() == 0) begin
					report_mismatch("response with no command outstanding",
						32'(rsp.length), 32'(0));
				end else begin
					want = due_responses.pop_front();
					if (rsp.read_token !== want.read_token)
						report_mismatch("read_token", rsp.read_token, want.read_token);
					if (rsp.length !== want.length)
						report_mismatch("length", 32'(rsp.length), 32'(want.length));
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
				end
			end
		end
	end

	always @(negedge clk) begin : drive
		logic idle;
		if (arst_n) begin
			if (!cmd_valid || cmd_took) begin
				idle = !calm && ($urandom_range(99) < 17);
				if (!idle && cmd_backlog.size() > 0) begin
					cmd <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			rsp_stall <= hold_rsp || (!calm && ($urandom_range(99) < 17));
		end
	end

	initial begin
		wait (cmds_taken >= 800);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (80) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d responses still due.", due_responses.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int mode;
		int pick;
		int pos;
		token_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
			32'h5A5A_A5A5, 32'h1234_5678};

		push_cmd(CMD_GET, 0, 32'h0);
		push_cmd(CMD_DEL_IDX, 0, 32'h0);
		push_cmd(CMD_DEL_VAL, 0, 32'h0);
		push_cmd(CMD_APPEND, 15, 32'h0000_0000);
		push_cmd(CMD_APPEND, 0, 32'hFFFF_FFFF);
		push_cmd(CMD_APPEND, 0, 32'h0000_0000);
		push_cmd(CMD_GET, 1, 32'hFFFF_FFFF);
		push_cmd(CMD_GET, 15, 32'h0);
		push_cmd(CMD_DEL_VAL, 0, 32'h0000_0000);
		push_cmd(CMD_GET, 0, 32'h0);
		push_cmd(CMD_GET, 1, 32'h0);
		for (int k = 0; k < 14; k++)
			push_cmd(CMD_APPEND, k, $urandom);
		push_cmd(CMD_APPEND, 0, 32'hFFFF_FFFF);
		push_cmd(CMD_GET, 15, 32'h0);
		push_cmd(CMD_DEL_IDX, 15, 32'h0);
		push_cmd(CMD_DEL_IDX, 0, 32'h0);
		push_cmd(CMD_DEL_VAL, 0, 32'hDEAD_BEEF);
		push_cmd(CMD_DEL_IDX, 15, 32'h0);

		for (int blk = 0; blk < 50; blk++) begin
			mode = $urandom_range(2);
			for (int n = 0; n < 40; n++) begin
				pick = $urandom_range(99);
				pos = ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom_range(3);
				if (mode == 0) begin
					if (pick < 55) push_cmd(CMD_APPEND, pos, pick_token());
					else if (pick < 70) push_cmd(CMD_GET, pos, pick_token());
					else if (pick < 85) push_cmd(CMD_DEL_IDX, pos, pick_token());
					else push_cmd(CMD_DEL_VAL, pos, pick_token());
				end else if (mode == 1) begin
					if (pick < 20) push_cmd(CMD_APPEND, pos, pick_token());
					else if (pick < 35) push_cmd(CMD_GET, pos, pick_token());
					else if (pick < 70) push_cmd(CMD_DEL_IDX, pos, pick_token());
					else push_cmd(CMD_DEL_VAL, pos, pick_token());
				end else begin
					if (pick < 30) push_cmd(CMD_APPEND, pos, pick_token());
					else if (pick < 55) push_cmd(CMD_GET, pos, pick_token());
					else if (pick < 75) push_cmd(CMD_DEL_IDX, pos, pick_token());
					else push_cmd(CMD_DEL_VAL, pos, pick_token());
				end
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (cmd_backlog.size() != 0 || cmd_valid);
		do @(posedge clk); while (due_responses.size() != 0);
		repeat (8) @(posedge clk);

		$display("Ran %0d commands and checked %0d responses; list length reached %0d.",
			cmds_taken, rsps_taken, longest_list);
		$display("Status mix: %0d ok, %0d out of range, %0d not found, %0d full.",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_MISSING],
			status_seen[ST_FULL]);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches found.", error_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- ordered_list_engine.f -----
design/ole_pkg.sv
design/ole_cell.sv
design/ole_chain.sv
design/ordered_list_engine.sv
design/ole_checker.sv
sim/testbench.sv
